>>> rtl/current_sensor_rms_dc_meter_defines.svh
// Assertion macros for the current meter checker.
`ifndef CURRENT_SENSOR_RMS_DC_METER_DEFINES_SVH
`define CURRENT_SENSOR_RMS_DC_METER_DEFINES_SVH

// Check a property on the checker clock, skipped during reset.
`define CSRDM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property that must also hold while reset is applied.
`define CSRDM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/csrdm_pkg.sv
// Package: shared types, constants and codes of the current meter.
package csrdm_pkg;

  localparam int MAX_WINDOW_SAMPLES = 4096;
  localparam int CAL_SAMPLES        = 10;
  localparam int DC_SAMPLES         = 5;

  localparam int SMP_W   = 10;
  localparam int CUR_W   = 20;
  localparam int ACC_W   = 34;
  localparam int CNT_W   = $clog2(MAX_WINDOW_SAMPLES + 1);
  localparam int DVD_W   = 49;
  localparam int SQ_TOP  = ((DVD_W - 1) / 2) * 2;
  localparam int ROOT_W  = SQ_TOP / 2 + 1;
  localparam int SQ_W    = DVD_W + 1;
  localparam int SCL_W   = 29;
  localparam int MAG_W   = 17;
  localparam int PROD_W  = 55;
  localparam int ITER_W  = $clog2(DVD_W + 1);
  localparam int CUR_LIMIT = 400000;
  localparam int Q_DEPTH = 2;
  localparam int CFG_W   = 16;

  localparam int CAL_SHIFT = 16;
  localparam int CAL_RECIP = ((1 << CAL_SHIFT) + CAL_SAMPLES - 1) / CAL_SAMPLES;
  localparam int DC_SHIFT  = 24;
  localparam int DC_RECIP  = ((1 << DC_SHIFT) + DC_SAMPLES - 1) / DC_SAMPLES;
  localparam int DC_Y_MAX  = CUR_LIMIT * DC_SAMPLES;
  localparam int RCP_W     = 21;
  localparam int RCP_K_W   = 22;
  localparam int RCP_P_W   = RCP_W + RCP_K_W + 1;

  localparam logic [1:0] MODE_CAL = 2'd0;
  localparam logic [1:0] MODE_AC  = 2'd1;
  localparam logic [1:0] MODE_DC  = 2'd2;

  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_VCC  = 2'd1;
  localparam logic [1:0] REG_APV  = 2'd2;

  localparam logic [1:0] RES_CAL = 2'd0;
  localparam logic [1:0] RES_RMS = 2'd1;
  localparam logic [1:0] RES_DC  = 2'd2;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  typedef enum logic [1:0] {
    OP_CAL,
    OP_AC_SMP,
    OP_AC_TICK,
    OP_DC
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [SMP_W-1:0] sample;
  } job_item_t;

  typedef enum logic [1:0] {
    JOB_CAL,
    JOB_AC,
    JOB_DC
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SQRT,
    ST_AC_MUL,
    ST_AC_FIN,
    ST_DC_MUL,
    ST_DC_RND,
    ST_RECIP
  } state_t;

  typedef struct packed {
    logic push;
    logic full;
  } front_ctl_t;

endpackage

>>> rtl/csrdm_if.sv
// Interfaces: sample input channel and result output channel.
interface csrdm_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [csrdm_pkg::SMP_W-1:0]   sample;
  modport source (output valid, kind, sample, input ready);
  modport sink (input valid, kind, sample, output ready);
endinterface

interface csrdm_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [csrdm_pkg::CUR_W-1:0] current_ma;
  logic [csrdm_pkg::SMP_W-1:0]        zero_level;
  logic [1:0]                         result_type;
  logic                               empty_window;
  logic                               overflow;
  modport source (output valid, current_ma, zero_level, result_type, empty_window, overflow,
                  input ready);
  modport sink (input valid, current_ma, zero_level, result_type, empty_window, overflow,
                output ready);
endinterface

>>> rtl/current_sensor_rms_dc_meter.sv
// Top level: current meter with calibration, RMS and DC measurement.
//
//  channel  | dir | beat contents
//  in_ch    | in  | kind, sample
//  out_ch   | out | current_ma, zero_level, result_type, empty_window, overflow
//  cfg_*    | in  | we, index, data (mode, vcc_millivolts, amps_per_volt_q8)
//
// A sample that adds to a run is accumulated in ST_IDLE. After the closing beat leaves the
// queue, a calibrate result passes ST_RECIP, a DC result ST_DC_MUL, ST_DC_RND and ST_RECIP,
// and an RMS result the 49-step divider, the 25-step root, ST_AC_MUL and ST_AC_FIN. Reset is
// synchronous, active low; zero level resets to 512. The back end holds while a result
// waits; a two-entry queue lets input beats land while it works or out_ch stalls.
module current_sensor_rms_dc_meter (
  input  logic                        clk,
  input  logic                        rst_n,
  csrdm_in_if.sink                    in_ch,
  csrdm_out_if.source                 out_ch,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [csrdm_pkg::CFG_W-1:0] cfg_data
);
  import csrdm_pkg::*;

  logic [1:0]       mode_r;
  logic [12:0]      vcc_r;
  logic [15:0]      apv_r;
  logic [SCL_W-1:0] scale_r;
  logic             clear_run;
  front_ctl_t       fctl;
  job_item_t        f_item;
  job_item_t        q_item;
  logic             q_full;
  logic             q_pop;
  logic             q_not_empty;

  assign clear_run = cfg_we && (cfg_index == REG_MODE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_CAL;
      vcc_r  <= 13'd5000;
      apv_r  <= 16'd1384;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE: mode_r <= cfg_data[1:0];
        REG_VCC:  vcc_r  <= cfg_data[12:0];
        REG_APV:  apv_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    scale_r <= SCL_W'(vcc_r * apv_r);
  end

  csrdm_front u_front (
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_kind   (in_ch.kind),
    .in_sample (in_ch.sample),
    .mode      (mode_r),
    .q_full    (q_full),
    .ctl       (fctl),
    .item      (f_item)
  );

  csrdm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fctl.push),
    .wr_item   (f_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rd_item   (q_item)
  );

  csrdm_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .clear_run        (clear_run),
    .scale            (scale_r),
    .q_not_empty      (q_not_empty),
    .q_item           (q_item),
    .q_pop            (q_pop),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_current_ma   (out_ch.current_ma),
    .out_zero_level   (out_ch.zero_level),
    .out_result_type  (out_ch.result_type),
    .out_empty_window (out_ch.empty_window),
    .out_overflow     (out_ch.overflow)
  );

endmodule

>>> rtl/csrdm_front.sv
// Front end: accept beats, classify by mode and drop those without effect.
module csrdm_front (
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_kind,
  input  logic [csrdm_pkg::SMP_W-1:0] in_sample,
  input  logic [1:0]                  mode,
  input  logic                        q_full,
  output csrdm_pkg::front_ctl_t       ctl,
  output csrdm_pkg::job_item_t        item
);
  import csrdm_pkg::*;

  logic keep;

  always_comb begin
    keep    = 1'b0;
    item.op = OP_CAL;
    unique case (mode)
      MODE_CAL: begin
        keep    = (in_kind == KIND_SAMPLE);
        item.op = OP_CAL;
      end
      MODE_AC: begin
        keep    = 1'b1;
        item.op = (in_kind == KIND_TICK) ? OP_AC_TICK : OP_AC_SMP;
      end
      MODE_DC: begin
        keep    = (in_kind == KIND_SAMPLE);
        item.op = OP_DC;
      end
      default: begin
        keep    = 1'b0;
        item.op = OP_CAL;
      end
    endcase
    item.sample = in_sample;
  end

  assign in_ready = !q_full;
  assign ctl.full = q_full;
  assign ctl.push = in_valid && !q_full && keep;

endmodule

>>> rtl/csrdm_queue.sv
// Queue: short FIFO of classified jobs between front and back end.
module csrdm_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  csrdm_pkg::job_item_t  wr_item,
  output logic                  full,
  input  logic                  pop,
  output logic                  not_empty,
  output csrdm_pkg::job_item_t  rd_item
);
  import csrdm_pkg::*;

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

  job_item_t              mem_r [Q_DEPTH];
  logic [PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [$clog2(Q_DEPTH+1)-1:0] cnt_r, cnt_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (p == PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  assign full      = (cnt_r == ($clog2(Q_DEPTH+1))'(Q_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign rd_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

>>> rtl/csrdm_back.sv
// Back end: accumulate, divide, square root, scale and drive the result register.
module csrdm_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               clear_run,
  input  logic [csrdm_pkg::SCL_W-1:0]        scale,
  input  logic                               q_not_empty,
  input  csrdm_pkg::job_item_t               q_item,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [csrdm_pkg::CUR_W-1:0] out_current_ma,
  output logic [csrdm_pkg::SMP_W-1:0]        out_zero_level,
  output logic [1:0]                         out_result_type,
  output logic                               out_empty_window,
  output logic                               out_overflow
);
  import csrdm_pkg::*;

  state_t                  state_r, state_nxt;
  job_t                    job_r, job_nxt;
  logic [ACC_W-1:0]        acc_r, acc_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [SMP_W-1:0]        zero_r, zero_nxt;
  logic [DVD_W-1:0]        dvd_r, dvd_nxt;
  logic [CNT_W-1:0]        dsr_r, dsr_nxt;
  logic [CNT_W-1:0]        rem_r, rem_nxt;
  logic [ITER_W-1:0]       iter_r, iter_nxt;
  logic [SQ_W-1:0]         v_r, v_nxt;
  logic [SQ_W-1:0]         res_r, res_nxt;
  logic [SQ_W-1:0]         bit_r, bit_nxt;
  logic [MAG_W-1:0]        mag_r, mag_nxt;
  logic                    neg_r, neg_nxt;
  logic                    ovf_r, ovf_nxt;
  logic [PROD_W-1:0]       prod_r, prod_nxt;
  logic                    ov_r, ov_nxt;
  logic signed [CUR_W-1:0] cur_r, cur_nxt;
  logic [1:0]              typ_r, typ_nxt;
  logic                    emp_r, emp_nxt;
  logic                    ovo_r, ovo_nxt;

  logic signed [SMP_W:0]   diff;
  logic [2*SMP_W+1:0]      sq;
  logic [ACC_W-1:0]        sum;
  logic [CNT_W-1:0]        cnt_inc;
  logic [CNT_W:0]          rem_t;
  logic [SQ_W-1:0]         trial;
  logic [PROD_W-1:0]       rnd;
  logic [CUR_W-1:0]        mag_sat;
  logic [RCP_P_W-1:0]      rcp_p;

  assign diff    = $signed({1'b0, q_item.sample}) - $signed({1'b0, zero_r});
  assign sq      = (2*SMP_W+2)'($signed(diff) * $signed(diff));
  assign cnt_inc = cnt_r + 1'b1;
  assign rem_t   = {rem_r, dvd_r[DVD_W-1]};
  assign trial   = res_r + bit_r;

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    zero_nxt  = zero_r;
    dvd_nxt   = dvd_r;
    dsr_nxt   = dsr_r;
    rem_nxt   = rem_r;
    iter_nxt  = iter_r;
    v_nxt     = v_r;
    res_nxt   = res_r;
    bit_nxt   = bit_r;
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    ovf_nxt   = ovf_r;
    prod_nxt  = prod_r;
    ov_nxt    = ov_r && !out_ready;
    cur_nxt   = cur_r;
    typ_nxt   = typ_r;
    emp_nxt   = emp_r;
    ovo_nxt   = ovo_r;
    q_pop     = 1'b0;
    sum       = '0;
    rnd       = '0;
    mag_sat   = '0;
    rcp_p     = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (q_not_empty && !ov_r) begin
          q_pop    = 1'b1;
          rem_nxt  = '0;
          iter_nxt = ITER_W'(DVD_W);
          unique case (q_item.op)
            OP_CAL: begin
              sum = acc_r + ACC_W'(q_item.sample);
              if (cnt_inc >= CNT_W'(CAL_SAMPLES)) begin
                dvd_nxt   = DVD_W'(sum);
                job_nxt   = JOB_CAL;
                acc_nxt   = '0;
                cnt_nxt   = '0;
                state_nxt = ST_RECIP;
              end else begin
                acc_nxt = sum;
                cnt_nxt = cnt_inc;
              end
            end
            OP_AC_SMP: begin
              if (cnt_r < CNT_W'(MAX_WINDOW_SAMPLES)) begin
                acc_nxt = acc_r + ACC_W'(sq);
                cnt_nxt = cnt_inc;
              end
            end
            OP_AC_TICK: begin
              acc_nxt = '0;
              cnt_nxt = '0;
              ovf_nxt = (cnt_r >= CNT_W'(MAX_WINDOW_SAMPLES));
              if (cnt_r == '0) begin
                ov_nxt  = 1'b1;
                cur_nxt = '0;
                typ_nxt = RES_RMS;
                emp_nxt = 1'b1;
                ovo_nxt = 1'b0;
              end else begin
                dvd_nxt   = {acc_r[DVD_W-17:0], 16'd0};
                dsr_nxt   = cnt_r;
                job_nxt   = JOB_AC;
                state_nxt = ST_DIV;
              end
            end
            OP_DC: begin
              sum = acc_r + ACC_W'($signed(diff));
              if (cnt_inc >= CNT_W'(DC_SAMPLES)) begin
                neg_nxt   = sum[ACC_W-1];
                mag_nxt   = sum[ACC_W-1] ? MAG_W'(-sum) : MAG_W'(sum);
                acc_nxt   = '0;
                cnt_nxt   = '0;
                state_nxt = ST_DC_MUL;
              end else begin
                acc_nxt = sum;
                cnt_nxt = cnt_inc;
              end
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      ST_DIV: begin
        if (rem_t >= {1'b0, dsr_r}) begin
          rem_nxt = CNT_W'(rem_t - {1'b0, dsr_r});
          dvd_nxt = {dvd_r[DVD_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_t[CNT_W-1:0];
          dvd_nxt = {dvd_r[DVD_W-2:0], 1'b0};
        end
        iter_nxt = iter_r - 1'b1;
        if (iter_r == ITER_W'(1)) begin
          v_nxt     = SQ_W'(dvd_nxt);
          res_nxt   = '0;
          bit_nxt   = SQ_W'(1) << SQ_TOP;
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (bit_r == '0) begin
          state_nxt = ST_AC_MUL;
        end else begin
          if (v_r >= trial) begin
            v_nxt   = v_r - trial;
            res_nxt = (res_r >> 1) + bit_r;
          end else begin
            res_nxt = res_r >> 1;
          end
          bit_nxt = bit_r >> 2;
        end
      end
      ST_AC_MUL: begin
        prod_nxt  = PROD_W'(res_r[ROOT_W-1:0] * scale);
        state_nxt = ST_AC_FIN;
      end
      ST_AC_FIN: begin
        rnd       = (prod_r + (PROD_W'(1) << 25)) >> 26;
        mag_sat   = (rnd > PROD_W'(CUR_LIMIT)) ? CUR_W'(CUR_LIMIT) : rnd[CUR_W-1:0];
        cur_nxt   = $signed(mag_sat);
        ov_nxt    = 1'b1;
        typ_nxt   = RES_RMS;
        emp_nxt   = 1'b0;
        ovo_nxt   = ovf_r;
        state_nxt = ST_IDLE;
      end
      ST_DC_MUL: begin
        prod_nxt  = PROD_W'(mag_r * scale);
        state_nxt = ST_DC_RND;
      end
      ST_DC_RND: begin
        rnd       = (prod_r + PROD_W'(DC_SAMPLES * (1 << 17))) >> 18;
        dvd_nxt   = (rnd > PROD_W'(DC_Y_MAX)) ? DVD_W'(DC_Y_MAX) : DVD_W'(rnd);
        job_nxt   = JOB_DC;
        state_nxt = ST_RECIP;
      end
      ST_RECIP: begin
        unique case (job_r)
          JOB_CAL: begin
            rcp_p    = dvd_r[RCP_W-1:0] * RCP_K_W'(CAL_RECIP);
            zero_nxt = rcp_p[CAL_SHIFT +: SMP_W];
            cur_nxt  = '0;
            typ_nxt  = RES_CAL;
          end
          default: begin
            rcp_p   = dvd_r[RCP_W-1:0] * RCP_K_W'(DC_RECIP);
            mag_sat = rcp_p[DC_SHIFT +: CUR_W];
            cur_nxt = neg_r ? -$signed(mag_sat) : $signed(mag_sat);
            typ_nxt = RES_DC;
          end
        endcase
        ov_nxt    = 1'b1;
        emp_nxt   = 1'b0;
        ovo_nxt   = 1'b0;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (clear_run) begin
      acc_nxt = '0;
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      job_r   <= JOB_CAL;
      acc_r   <= '0;
      cnt_r   <= '0;
      zero_r  <= SMP_W'(512);
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      job_r   <= job_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      zero_r  <= zero_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r  <= dvd_nxt;
    dsr_r  <= dsr_nxt;
    rem_r  <= rem_nxt;
    iter_r <= iter_nxt;
    v_r    <= v_nxt;
    res_r  <= res_nxt;
    bit_r  <= bit_nxt;
    mag_r  <= mag_nxt;
    neg_r  <= neg_nxt;
    ovf_r  <= ovf_nxt;
    prod_r <= prod_nxt;
    cur_r  <= cur_nxt;
    typ_r  <= typ_nxt;
    emp_r  <= emp_nxt;
    ovo_r  <= ovo_nxt;
  end

  assign out_valid        = ov_r;
  assign out_current_ma   = cur_r;
  assign out_zero_level   = zero_r;
  assign out_result_type  = typ_r;
  assign out_empty_window = emp_r;
  assign out_overflow     = ovo_r;

endmodule

>>> rtl/csrdm_checker.sv
// Checker: port-level properties of the current meter, bound to the top level.
`include "current_sensor_rms_dc_meter_defines.svh"

module csrdm_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [csrdm_pkg::CUR_W-1:0] out_current_ma,
  input logic [1:0]                         out_result_type,
  input logic                               out_empty_window,
  input logic                               out_overflow
);
  import csrdm_pkg::*;

  `CSRDM_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(out_current_ma), "stalled result changed")
  `CSRDM_ASSERT(a_type, out_valid |-> out_result_type == RES_CAL || out_result_type == RES_RMS || out_result_type == RES_DC, "bad result type")
  `CSRDM_ASSERT(a_empty, out_valid && out_empty_window |-> out_result_type == RES_RMS && out_current_ma == 0 && !out_overflow, "bad empty window result")
  `CSRDM_ASSERT(a_cal, out_valid && out_result_type == RES_CAL |-> out_current_ma == 0 && !out_overflow, "bad calibration result")
  `CSRDM_ASSERT_RST(a_rst, !$past(rst_n) |-> !out_valid, "result valid after reset")

endmodule

bind current_sensor_rms_dc_meter csrdm_checker u_csrdm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_current_ma   (out_ch.current_ma),
  .out_result_type  (out_ch.result_type),
  .out_empty_window (out_ch.empty_window),
  .out_overflow     (out_ch.overflow)
);
